[hdl/lcdns_pkg.sv]
// ----------------------------------------------------------------------------
// lcdns_pkg
// Shared types, codes and constants of the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

    localparam int TIMER_BITS = 16;
    localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;

    typedef logic [TIMER_BITS-1:0] timer_t;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_CMD    = 3'd1;
    localparam logic [2:0] ACT_DATA   = 3'd2;
    localparam logic [2:0] ACT_CURSOR = 3'd3;
    localparam logic [2:0] ACT_INIT   = 3'd4;

    localparam logic [2:0] REG_POWER_ON  = 3'd0;
    localparam logic [2:0] REG_INIT_GAP  = 3'd1;
    localparam logic [2:0] REG_EN_HIGH   = 3'd2;
    localparam logic [2:0] REG_AFTER     = 3'd3;
    localparam logic [2:0] REG_SHORT     = 3'd4;
    localparam logic [2:0] REG_LONG      = 3'd5;
    localparam logic [2:0] REG_DATA_WAIT = 3'd6;

    typedef struct packed {
        logic [15:0] power_on_wait_us;
        logic [15:0] init_gap_us;
        logic [7:0]  enable_high_us;
        logic [9:0]  after_pulse_us;
        logic [15:0] short_cmd_wait_us;
        logic [15:0] long_cmd_wait_us;
        logic [15:0] data_wait_us;
    } cfg_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] byte_value;
        logic       row;
        logic [5:0] column;
    } item_t;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic       enable;
        logic [3:0] data_nibble;
        logic       busy_res;
        logic       refused;
    } result_t;

endpackage

[hdl/lcdns_cfg.sv]
// ----------------------------------------------------------------------------
// lcdns_cfg
// Timing registers of the sequencer, written through the plain write port.
// ----------------------------------------------------------------------------
module lcdns_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_addr,
    input  logic [15:0]      cfg_wdata,
    output lcdns_pkg::cfg_t  cfg
);
    import lcdns_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_POWER_ON:  cfg_next.power_on_wait_us  = cfg_wdata;
                REG_INIT_GAP:  cfg_next.init_gap_us       = cfg_wdata;
                REG_EN_HIGH:   cfg_next.enable_high_us    = cfg_wdata[7:0];
                REG_AFTER:     cfg_next.after_pulse_us    = cfg_wdata[9:0];
                REG_SHORT:     cfg_next.short_cmd_wait_us = cfg_wdata;
                REG_LONG:      cfg_next.long_cmd_wait_us  = cfg_wdata;
                REG_DATA_WAIT: cfg_next.data_wait_us      = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_on_wait_us  <= 16'd50000;
            cfg_reg.init_gap_us       <= 16'd5000;
            cfg_reg.enable_high_us    <= 8'd1;
            cfg_reg.after_pulse_us    <= 10'd100;
            cfg_reg.short_cmd_wait_us <= 16'd100;
            cfg_reg.long_cmd_wait_us  <= 16'd2000;
            cfg_reg.data_wait_us      <= 16'd1000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/lcdns_in_reg.sv]
// ----------------------------------------------------------------------------
// lcdns_in_reg
// Input register: unpack and hold one request until the sequencer takes it.
// ----------------------------------------------------------------------------
module lcdns_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,
    input  logic [2:0]       s_tuser,
    input  logic             item_take,
    output logic             item_valid,
    output lcdns_pkg::item_t item
);
    import lcdns_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  load;

    assign s_tready = !valid_reg || item_take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (item_take)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next           = 1'b1;
            item_next.action     = s_tuser;
            item_next.byte_value = s_tdata[7:0];
            item_next.row        = s_tdata[8];
            item_next.column     = s_tdata[14:9];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hdl/lcdns_seq.sv]
// ----------------------------------------------------------------------------
// lcdns_seq
// Nibble sequencer state, one-request update and result register.
// ----------------------------------------------------------------------------
module lcdns_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  lcdns_pkg::cfg_t    cfg,
    input  logic               item_valid,
    input  lcdns_pkg::item_t   item,
    output logic               item_take,
    input  logic               m_tready,
    output logic               m_tvalid,
    output lcdns_pkg::result_t result
);
    import lcdns_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_POWER  = 3'd1;
    localparam logic [2:0] PH_HIGH   = 3'd2;
    localparam logic [2:0] PH_LOW    = 3'd3;
    localparam logic [2:0] PH_SETTLE = 3'd4;

    localparam int CHAIN_STEPS = 4;

    typedef struct packed {
        logic [2:0] phase;
        timer_t     wait_cnt;
        logic [7:0] byte_latch;
        logic       select_latch;
        logic       low_pending;
        logic [3:0] init_step;
        logic [3:0] pin_nibble;
        logic       enable_level;
    } seq_state_t;

    function automatic timer_t sat_load(input logic [15:0] v);
        timer_t r;
        if (64'(v) > TIMER_MAX)
        begin
            r = '1;
        end
        else
        begin
            r = TIMER_BITS'(v);
        end
        return r;
    endfunction

    function automatic logic [7:0] init_cmd(input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0:    r = 8'h28;
            2'd1:    r = 8'h0C;
            2'd2:    r = 8'h06;
            default: r = 8'h01;
        endcase
        return r;
    endfunction

    function automatic seq_state_t pulse_start(input seq_state_t s, input logic [3:0] nib,
                                               input cfg_t c);
        seq_state_t r;
        r              = s;
        r.pin_nibble   = nib;
        r.enable_level = 1'b1;
        r.phase        = PH_HIGH;
        r.wait_cnt     = sat_load((c.enable_high_us == 8'd0) ? 16'd1 : 16'(c.enable_high_us));
        return r;
    endfunction

    function automatic seq_state_t byte_start(input seq_state_t s, input logic [7:0] b,
                                              input logic rs, input cfg_t c);
        seq_state_t r;
        r              = s;
        r.byte_latch   = b;
        r.select_latch = rs;
        r.low_pending  = 1'b1;
        return pulse_start(r, b[7:4], c);
    endfunction

    function automatic seq_state_t settle_start(input seq_state_t s, input logic [15:0] d);
        seq_state_t r;
        r          = s;
        r.phase    = PH_SETTLE;
        r.wait_cnt = sat_load(d);
        return r;
    endfunction

    function automatic seq_state_t advance(input seq_state_t s, input cfg_t c);
        seq_state_t r;
        logic [3:0] k;
        r = s;
        k = s.init_step - 4'd4;
        case (s.phase)
            PH_POWER:
            begin
                r.init_step = 4'd1;
                r = pulse_start(r, 4'h3, c);
            end
            PH_HIGH:
            begin
                r.enable_level = 1'b0;
                r.phase        = PH_LOW;
                r.wait_cnt     = sat_load(16'(c.after_pulse_us));
            end
            PH_LOW:
            begin
                if (s.low_pending)
                begin
                    r.low_pending = 1'b0;
                    r = pulse_start(r, s.byte_latch[3:0], c);
                end
                else if (s.init_step >= 4'd1 && s.init_step <= 4'd4)
                begin
                    r = settle_start(r, (s.init_step == 4'd1) ? c.init_gap_us :
                                        (s.init_step == 4'd2) ? c.short_cmd_wait_us : 16'd0);
                end
                else if (s.select_latch)
                begin
                    r = settle_start(r, c.data_wait_us);
                end
                else
                begin
                    r = settle_start(r, (s.byte_latch == 8'h01 || s.byte_latch == 8'h02) ?
                                        c.long_cmd_wait_us : c.short_cmd_wait_us);
                end
            end
            PH_SETTLE:
            begin
                if (s.init_step >= 4'd1 && s.init_step <= 4'd3)
                begin
                    r.init_step = 4'(s.init_step + 4'd1);
                    r = pulse_start(r, (s.init_step == 4'd3) ? 4'h2 : 4'h3, c);
                end
                else if (s.init_step >= 4'd4 && s.init_step <= 4'd7)
                begin
                    r.init_step = 4'(s.init_step + 4'd1);
                    r = byte_start(r, init_cmd(k[1:0]), 1'b0, c);
                end
                else if (s.init_step == 4'd8)
                begin
                    r.init_step = 4'd9;
                    r = settle_start(r, c.long_cmd_wait_us);
                end
                else
                begin
                    r.init_step = 4'd0;
                    r.phase     = PH_IDLE;
                    r.wait_cnt  = '0;
                end
            end
            default:
            begin
                r.phase    = PH_IDLE;
                r.wait_cnt = '0;
            end
        endcase
        return r;
    endfunction

    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    result_reg;
    result_t    result_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       busy;
    logic       refused;
    logic       run_chain;
    logic [7:0] cursor_addr;

    assign item_take   = item_valid && (!out_valid_reg || m_tready);
    assign busy        = (state_reg.phase != PH_IDLE);
    assign cursor_addr = 8'((item.row ? 8'hC0 : 8'h80) + {2'b00, item.column});

    always_comb
    begin
        state_next = state_reg;
        refused    = 1'b0;
        run_chain  = 1'b0;
        if (item_take)
        begin
            case (item.action)
                ACT_TICK:
                begin
                    if (busy)
                    begin
                        if (state_reg.wait_cnt != '0)
                        begin
                            state_next.wait_cnt = state_reg.wait_cnt - 1'b1;
                        end
                        run_chain = 1'b1;
                    end
                end
                ACT_CMD, ACT_DATA, ACT_CURSOR, ACT_INIT:
                begin
                    if (busy)
                    begin
                        refused = 1'b1;
                    end
                    else if (item.action == ACT_CMD)
                    begin
                        state_next = byte_start(state_reg, item.byte_value, 1'b0, cfg);
                    end
                    else if (item.action == ACT_DATA)
                    begin
                        state_next = byte_start(state_reg, item.byte_value, 1'b1, cfg);
                    end
                    else if (item.action == ACT_CURSOR)
                    begin
                        state_next = byte_start(state_reg, cursor_addr, 1'b0, cfg);
                    end
                    else
                    begin
                        state_next.select_latch = 1'b0;
                        state_next.low_pending  = 1'b0;
                        state_next.init_step    = 4'd0;
                        state_next.enable_level = 1'b0;
                        state_next.phase        = PH_POWER;
                        state_next.wait_cnt     = sat_load(cfg.power_on_wait_us);
                        run_chain               = 1'b1;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
            // pass zero-length phases at once
            if (run_chain)
            begin
                for (int i = 0; i < CHAIN_STEPS; i++)
                begin
                    if (state_next.phase != PH_IDLE && state_next.wait_cnt == '0)
                    begin
                        state_next = advance(state_next, cfg);
                    end
                end
            end
        end

        result_next.reg_select  = state_next.select_latch;
        result_next.read_write  = 1'b0;
        result_next.enable      = state_next.enable_level;
        result_next.data_nibble = state_next.pin_nibble;
        result_next.busy_res    = (state_next.phase != PH_IDLE);
        result_next.refused     = refused;

        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (item_take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

`ifndef NO_ASSERTIONS
    a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.refused |-> result_reg.busy_res)
        else $error("refused result without busy");

    a_enable_in_high: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.enable_level |-> state_reg.phase == PH_HIGH)
        else $error("enable high outside pulse phase");

    a_busy_counts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != PH_IDLE |-> state_reg.wait_cnt != '0)
        else $error("busy with expired wait");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !item_take |=> $stable(state_reg))
        else $error("state moved without a request");
`endif

endmodule

[hdl/char_lcd_nibble_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// 4-bit character LCD write sequencer: ticks and requests in, pin levels out.
// ----------------------------------------------------------------------------
//  channel  direction  content
//  s_*      in         request: tuser action, tdata byte/row/column
//  m_*      out        pins RS, RW, E, D7..D4, busy and refused flags
//  cfg_*    in         timing register writes, no read-back
//
// One request per clock while the output is not stalled; the result is in the
// output register in the cycle after the request leaves the input register.
// Zero-length phases resolve before the result is registered. Reset clears
// the sequencer to idle and loads the default timings. A stalled output holds
// its result and the input register keeps one more request.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // byte_value[7:0], row[8], column[14:9]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // reg_select[0], read_write[1], enable[2],
                                   // data_nibble[6:3], busy_res[7], refused[8]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import lcdns_pkg::*;

    cfg_t    cfg;
    item_t   item;
    logic    item_valid;
    logic    item_take;
    result_t result;

    lcdns_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lcdns_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_take  (item_take),
        .item_valid (item_valid),
        .item       (item)
    );

    lcdns_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .result     (result)
    );

    assign m_tdata = {7'd0, result.refused, result.busy_res, result.data_nibble,
                      result.enable, result.read_write, result.reg_select};

endmodule
